FILE: rtl/hmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmb_pkg: shared types and constants of the majority bundling block
// Holds the mode codes, the queue entry type and the xorshift step function.
// ----------------------------------------------------------------------------
package hmb_pkg;

    localparam logic [1:0] MODE_ADD      = 2'd0;
    localparam logic [1:0] MODE_ADD_EMIT = 2'd1;
    localparam logic [1:0] MODE_EMIT     = 2'd2;
    localparam logic [1:0] MODE_EMIT_ALT = 2'd3;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [63:0] TIE_NAME   = 64'h65_69_74_3a_69_6b_6f_74;

    typedef struct packed {
        logic        add;
        logic        emit;
        logic [31:0] seed;
    } t_cmd;

    function automatic logic [31:0] xs_step(input logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic [31:0] tie_seed();
        logic [31:0] h;
        h = FNV_OFFSET;
        for (int i = 0; i < 8; i++) begin
            h = h ^ {24'd0, TIE_NAME[i*8 +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/hypervector_majority_bundle_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hypervector_majority_bundle_core: majority bundling of seeded hypervectors
// Accepts seed commands and emits the majority vector word by word.
// ----------------------------------------------------------------------------
// Input beats carry a mode and a seed on a valid/ready channel. Mode 0 adds
// the seed, mode 1 adds it and then emits, modes 2 and 3 emit only.
// A two-entry queue decouples command intake from the counting engine.
// The engine takes a queued command when idle. Adding a seed then steps
// through the rows, one xorshift word pair per cycle, and the next seed
// waits until the engine is idle; the pace is set by the read-modify-write of
// one counter row a cycle, whose write lands in the cycle after its read.
// An emit delivers WORDS output beats, word_index rising from 0, last on the
// final word, overflow when seeds were dropped past 65535 in that bundle.
// On an idle block a mode 2 command passes from the queue through S_IDLE and
// S_RD, which reads a counter row, to the output register; the other beats
// follow one a cycle while the receiver takes them. Mode 1 runs S_ADD first.
// After reset the engine clears the counters and builds the tie-break
// pattern in S_CLR; commands queue up meanwhile.
// When the receiver stalls, the output register holds its beat, the emit
// sequence pauses until the beat is taken and a full queue holds off input.
// ----------------------------------------------------------------------------
module hypervector_majority_bundle_core #(
    parameter int WORDS = 16,
    parameter int DIMS  = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_seed,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_word,
    output logic [5:0]       o_word_index,
    output logic             o_last,
    output logic             o_overflow
);
    import hmb_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_ready;

    hmb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_seed(i_seed),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    hmb_back #(.WORDS(WORDS), .DIMS(DIMS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_word(o_word), .o_word_index(o_word_index),
        .o_last(o_last), .o_overflow(o_overflow)
    );
endmodule
`default_nettype wire

FILE: rtl/hmb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmb_front: command classifier and queue
// Decodes the mode of each beat and holds commands in a two-entry queue.
// ----------------------------------------------------------------------------
module hmb_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [1:0]     i_mode,
    input  wire logic [31:0]    i_seed,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_ready,
    output hmb_pkg::t_cmd       o_cmd
);
    import hmb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd.seed = i_seed;
        case (i_mode)
            MODE_ADD:      begin w_cmd.add = 1'b1; w_cmd.emit = 1'b0; end
            MODE_ADD_EMIT: begin w_cmd.add = 1'b1; w_cmd.emit = 1'b1; end
            default:       begin w_cmd.add = 1'b0; w_cmd.emit = 1'b1; end
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/hmb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmb_back: counter memory and emit engine
// Expands seeds one word a cycle into the counter memory and emits words.
// ----------------------------------------------------------------------------
module hmb_back #(
    parameter int WORDS = 16,
    parameter int DIMS  = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  hmb_pkg::t_cmd       i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [63:0]         o_word,
    output logic [5:0]          o_word_index,
    output logic                o_last,
    output logic                o_overflow
);
    import hmb_pkg::*;

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_ADD  = 5'b00100,
        S_RD   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_k;
    logic [31:0]   r_v;
    logic [31:0]   r_tv;
    logic [63:0]   r_tie [WORDS];
    logic          r_emit;
    logic [15:0]   r_total;
    logic          r_drop;
    logic [15:0]   r_mem [WORDS][64];
    logic [15:0]   r_rd [64];
    logic          r_aw;
    logic [AW-1:0] r_ak;
    logic [63:0]   r_abits;
    logic [63:0]   r_rtie;
    logic [AW-1:0] r_rdk;
    logic          r_rdv;
    logic          r_ov;
    logic [63:0]   r_oword;
    logic [5:0]    r_oidx;
    logic          r_olast;
    logic          r_oflag;
    logic [31:0]   w_v1, w_v2, w_t1, w_t2;
    logic [63:0]   w_bits;
    logic [63:0]   w_add;
    logic [63:0]   w_maj;
    logic          w_rd_go;
    logic          w_clr;

    assign w_v1 = xs_step(r_v);
    assign w_v2 = xs_step(w_v1);
    assign w_t1 = xs_step(r_tv);
    assign w_t2 = xs_step(w_t1);
    assign w_bits = {w_v2, w_v1};

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_rd_go = (r_state == S_RD) && !r_aw && (!r_ov || i_ready);
    assign w_clr = (r_state == S_CLR);

    always_comb begin
        for (int b = 0; b < 64; b++) begin
            w_add[b] = w_bits[b] && (32'(r_k) * 64 + b < DIMS);
        end
    end

    always_comb begin
        for (int b = 0; b < 64; b++) begin
            logic [16:0] tw;
            tw = {r_rd[b], 1'b0};
            if (!r_rdv) begin
                w_maj[b] = 1'b0;
            end else if (tw > {1'b0, r_total}) begin
                w_maj[b] = 1'b1;
            end else if (tw == {1'b0, r_total}) begin
                w_maj[b] = r_rtie[b];
            end else begin
                w_maj[b] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 64; b++) begin
            if (w_clr || w_rd_go) begin
                r_mem[r_k][b] <= 16'd0;
            end else if (r_aw) begin
                r_mem[r_ak][b] <= r_rd[b] + {15'd0, r_abits[b]};
            end
            if (w_rd_go || r_state == S_ADD) begin
                r_rd[b] <= r_mem[r_k][b];
            end
        end
        if (r_state == S_ADD) begin
            r_ak    <= r_k;
            r_abits <= w_add;
        end
        if (r_state == S_CLR) begin
            r_tie[r_k] <= {w_t2, w_t1};
            r_tv       <= w_t2;
        end
        if (w_rd_go) begin
            r_rtie <= r_tie[r_k];
            r_rdk  <= r_k;
        end
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_k     <= '0;
            r_tv    <= (tie_seed() == 32'd0) ? 32'd1 : tie_seed();
            r_total <= 16'd0;
            r_drop  <= 1'b0;
            r_emit  <= 1'b0;
            r_rdv   <= 1'b0;
            r_ov    <= 1'b0;
            r_aw    <= 1'b0;
        end else begin
            r_aw <= (r_state == S_ADD);
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_k <= r_k + 1'b1;
                    if (32'(r_k) == WORDS - 1) begin
                        r_k     <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_emit <= i_cmd.emit;
                        r_k    <= '0;
                        r_v    <= (i_cmd.seed == 32'd0) ? 32'd1 : i_cmd.seed;
                        if (i_cmd.add && r_total != 16'hFFFF) begin
                            r_state <= S_ADD;
                        end else begin
                            if (i_cmd.add) r_drop <= 1'b1;
                            r_state <= i_cmd.emit ? S_RD : S_IDLE;
                        end
                    end
                end
                S_ADD: begin
                    r_v <= w_v2;
                    r_k <= r_k + 1'b1;
                    if (32'(r_k) == WORDS - 1) begin
                        r_k     <= '0;
                        r_total <= r_total + 16'd1;
                        r_state <= r_emit ? S_RD : S_IDLE;
                    end
                end
                S_RD: begin
                    if (w_rd_go) begin
                        r_rdv <= 1'b1;
                        r_k   <= r_k + 1'b1;
                        if (32'(r_k) == WORDS - 1) begin
                            r_k     <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_rdv   <= 1'b0;
                        r_total <= 16'd0;
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLR;
            endcase
            if (r_rdv && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end
        end
        if (r_rdv && (!r_ov || i_ready)) begin
            r_oword <= w_maj;
            r_oidx  <= 6'(r_rdk);
            r_olast <= (32'(r_rdk) == WORDS - 1);
            r_oflag <= r_drop;
        end
    end

    assign o_valid      = r_ov;
    assign o_word       = r_oword;
    assign o_word_index = r_oidx;
    assign o_last       = r_olast;
    assign o_overflow   = r_oflag;
endmodule
`default_nettype wire
